[hw/rtl/erfi_pkg.sv]
// ----------------------------------------------------------------------------
// erfi_pkg: shared types and constants for the exchange-run fault injector
// Register map, field codes, port/pc match constants and the per-slot
// byte operation.
// ----------------------------------------------------------------------------
`default_nettype none

package erfi_pkg;

	localparam int SLOT_COUNT = 4;
	localparam int SLOT_REGS  = 4;

	localparam int BYTE_W     = 8;
	localparam int PORT_W     = 8;
	localparam int PC_W       = 16;
	localparam int SLOT_W     = 43;
	localparam int RUN_W      = 32;
	localparam int TARGET_W   = 31;
	localparam int HMODE_W    = 2;
	localparam int ACTION_W   = 2;
	localparam int DIR_W      = 2;
	localparam int SMODE_W    = 3;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_ADDR_W = 6;
	localparam int REG_IDX_W  = 3;

	// slot word fields
	localparam int SLOT_BYTE_LSB = 0;
	localparam int SLOT_MODE_LSB = 8;
	localparam int SLOT_RUN_LSB  = 11;

	// register indexes (byte address is 8 * index)
	localparam logic [REG_IDX_W-1:0] REG_SLOT0  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_SLOT1  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_SLOT2  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_SLOT3  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_TARGET = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_HMODE  = 3'd5;

	// slot modes
	localparam logic [SMODE_W-1:0] SM_OFF       = 3'd0;
	localparam logic [SMODE_W-1:0] SM_XOR_ALL   = 3'd1;
	localparam logic [SMODE_W-1:0] SM_REP_ALL   = 3'd2;
	localparam logic [SMODE_W-1:0] SM_XOR_FIRST = 3'd3;
	localparam logic [SMODE_W-1:0] SM_REP_FIRST = 3'd4;
	localparam logic [SMODE_W-1:0] SM_XOR_TAIL  = 3'd5;

	// handoff modes and actions
	localparam logic [HMODE_W-1:0]  HM_OFF      = 2'd0;
	localparam logic [HMODE_W-1:0]  HM_NOW      = 2'd1;
	localparam logic [HMODE_W-1:0]  HM_DEFER    = 2'd2;
	localparam logic [ACTION_W-1:0] HA_NORMAL   = 2'd0;
	localparam logic [ACTION_W-1:0] HA_FORCE    = 2'd1;
	localparam logic [ACTION_W-1:0] HA_SUPPRESS = 2'd2;

	// event kinds and access kinds
	localparam logic EV_PORT  = 1'b0;
	localparam logic EV_PORTC = 1'b1;
	localparam logic ACC_IN   = 1'b0;
	localparam logic ACC_OUT  = 1'b1;

	// exchange directions
	localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
	localparam logic [DIR_W-1:0] DIR_M2S  = 2'd1;
	localparam logic [DIR_W-1:0] DIR_S2M  = 2'd2;

	// match constants
	localparam logic [PORT_W-1:0] PORT_WAIT = 8'hFE;
	localparam logic [PORT_W-1:0] PORT_M2S  = 8'hFD;
	localparam logic [PORT_W-1:0] PORT_S2M  = 8'hFC;
	localparam logic [PC_W-1:0]   PC_WAIT   = 16'h3853;
	localparam logic [PC_W-1:0]   PC_M2S_A  = 16'h37F4;
	localparam logic [PC_W-1:0]   PC_M2S_B  = 16'h3811;
	localparam logic [PC_W-1:0]   PC_S2M_A  = 16'h3863;
	localparam logic [PC_W-1:0]   PC_S2M_B  = 16'h3880;
	localparam logic [PC_W-1:0]   PC_S2M_C  = 16'hC269;

	typedef struct packed {
		logic [SLOT_REGS-1:0][SLOT_W-1:0] slot;
		logic [TARGET_W-1:0]              target;
		logic [HMODE_W-1:0]               hmode;
	} cfg_t;

	function automatic logic [DIR_W-1:0] direction_of(
		input logic              kind,
		input logic [PORT_W-1:0] port,
		input logic [PC_W-1:0]   pc
	);
		logic [DIR_W-1:0] d;
		d = DIR_NONE;
		if (kind == ACC_OUT && port == PORT_M2S && (pc == PC_M2S_A || pc == PC_M2S_B))
			d = DIR_M2S;
		else if (kind == ACC_IN && port == PORT_S2M &&
			(pc == PC_S2M_A || pc == PC_S2M_B || pc == PC_S2M_C))
			d = DIR_S2M;
		return d;
	endfunction

	// one slot acting on the byte left by the slot before it
	function automatic logic [BYTE_W-1:0] slot_apply(
		input logic [BYTE_W-1:0] b,
		input logic [SLOT_W-1:0] w,
		input logic [RUN_W-1:0]  run,
		input logic              start
	);
		logic [BYTE_W-1:0]  sb;
		logic [SMODE_W-1:0] sm;
		logic [RUN_W-1:0]   sr;
		logic [BYTE_W-1:0]  r;
		sb = w[SLOT_BYTE_LSB +: BYTE_W];
		sm = w[SLOT_MODE_LSB +: SMODE_W];
		sr = w[SLOT_RUN_LSB +: RUN_W];
		r  = b;
		if (sr == run) begin
			case (sm)
				SM_XOR_ALL:   r = b ^ sb;
				SM_REP_ALL:   r = sb;
				SM_XOR_FIRST: r = start ? (b ^ sb) : b;
				SM_REP_FIRST: r = start ? sb : b;
				SM_XOR_TAIL:  r = start ? b : (b ^ sb);
				default:      r = b;
			endcase
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/erfi_if.sv]
// ----------------------------------------------------------------------------
// erfi_if: access and result channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface erfi_in_if;
	logic                          valid;
	logic                          ready;
	logic                          mode;
	logic                          access_kind;
	logic [erfi_pkg::PORT_W-1:0]   port_number;
	logic [erfi_pkg::PC_W-1:0]     program_counter;
	logic [erfi_pkg::BYTE_W-1:0]   data_in;
	logic                          from_main;
	logic                          handoff_due;

	modport source (
		output valid, mode, access_kind, port_number, program_counter, data_in,
			from_main, handoff_due,
		input  ready
	);
	modport sink (
		input  valid, mode, access_kind, port_number, program_counter, data_in,
			from_main, handoff_due,
		output ready
	);
endinterface

interface erfi_out_if;
	logic                          valid;
	logic                          ready;
	logic [erfi_pkg::BYTE_W-1:0]   data_out;
	logic [erfi_pkg::ACTION_W-1:0] handoff_action;

	modport source (output valid, data_out, handoff_action, input ready);
	modport sink (input valid, data_out, handoff_action, output ready);
endinterface

`default_nettype wire

[hw/rtl/exchange_run_fault_injector_unit.sv]
// ----------------------------------------------------------------------------
// exchange_run_fault_injector_unit: exchange-run fault injector
// Classifies port accesses into exchange runs, corrupts sub-to-main bytes
// per slot and performs a one-time CPU handoff intervention.
// ----------------------------------------------------------------------------
// result: registered; a result beat is valid in the cycle after its access beat is accepted
// throughput: one beat per cycle while result.ready is high; run state updates at the accept edge
// the result register frees as soon as its beat is taken, so a new access
// is taken in the same cycle the previous result leaves
// reset: run counter all ones, run-start set, no direction, handoff idle,
// configuration cleared; no clearing pass
`default_nettype none

module exchange_run_fault_injector_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	erfi_in_if.sink                                  access,
	erfi_out_if.source                               result,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [erfi_pkg::CFG_ADDR_W-1:0]     paddr,
	input  wire logic [erfi_pkg::CFG_DATA_W-1:0]     pwdata,
	output logic      [erfi_pkg::CFG_DATA_W-1:0]     prdata,
	output logic                                     pready
);

	erfi_pkg::cfg_t                      cfg;

	logic [erfi_pkg::RUN_W-1:0]          run_counter_q;
	logic                                run_start_q;
	logic [erfi_pkg::DIR_W-1:0]          last_dir_q;
	logic                                armed_q;
	logic                                done_q;

	logic                                out_valid_q;
	logic [erfi_pkg::BYTE_W-1:0]         data_out_q;
	logic [erfi_pkg::ACTION_W-1:0]       action_q;

	logic                                accept;
	logic                                enabled;
	logic [erfi_pkg::RUN_W-1:0]          target_m1;
	logic [erfi_pkg::DIR_W-1:0]          dir;
	logic                                dir_new;
	logic [erfi_pkg::RUN_W-1:0]          run_next;
	logic                                start_eff;
	logic [erfi_pkg::BYTE_W-1:0]         byte_res;
	logic                                arm_hit;
	logic [erfi_pkg::ACTION_W-1:0]       act;
	logic                                done_set;
	logic [erfi_pkg::BYTE_W-1:0]         data_res;
	logic [erfi_pkg::ACTION_W-1:0]       action_res;

	erfi_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	assign pready       = 1'b1;
	assign access.ready = !out_valid_q || result.ready;
	assign accept       = access.valid && access.ready;

	assign result.valid          = out_valid_q;
	assign result.data_out       = data_out_q;
	assign result.handoff_action = action_q;

	assign enabled   = (cfg.target != '0) &&
		(cfg.hmode == erfi_pkg::HM_NOW || cfg.hmode == erfi_pkg::HM_DEFER);
	assign target_m1 = {1'b0, cfg.target} - erfi_pkg::RUN_W'(1);

	// run tracking and slot corruption
	always_comb begin
		dir       = erfi_pkg::direction_of(access.access_kind, access.port_number,
			access.program_counter);
		dir_new   = (dir != erfi_pkg::DIR_NONE) && (dir != last_dir_q);
		run_next  = dir_new ? run_counter_q + erfi_pkg::RUN_W'(1) : run_counter_q;
		start_eff = dir_new ? 1'b1 : run_start_q;
		byte_res  = access.data_in;
		if (dir == erfi_pkg::DIR_S2M) begin
			for (int i = 0; i < erfi_pkg::SLOT_COUNT; i++) begin
				byte_res = erfi_pkg::slot_apply(byte_res, cfg.slot[i], run_next, start_eff);
			end
		end
		arm_hit = enabled && !done_q && access.access_kind == erfi_pkg::ACC_IN &&
			access.port_number == erfi_pkg::PORT_WAIT &&
			access.program_counter == erfi_pkg::PC_WAIT &&
			run_counter_q == target_m1;
	end

	// handoff decision on port C reads
	always_comb begin
		act      = erfi_pkg::HA_NORMAL;
		done_set = 1'b0;
		if (armed_q && access.from_main && !done_q && enabled) begin
			if (cfg.hmode == erfi_pkg::HM_NOW) begin
				act      = access.handoff_due ? erfi_pkg::HA_NORMAL : erfi_pkg::HA_FORCE;
				done_set = 1'b1;
			end else if (access.handoff_due) begin
				act      = erfi_pkg::HA_SUPPRESS;
				done_set = 1'b1;
			end
		end
		if (access.mode == erfi_pkg::EV_PORTC) begin
			data_res   = '0;
			action_res = act;
		end else begin
			data_res   = byte_res;
			action_res = erfi_pkg::HA_NORMAL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_counter_q <= '1;
			run_start_q   <= 1'b1;
			last_dir_q    <= erfi_pkg::DIR_NONE;
			armed_q       <= 1'b0;
			done_q        <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (accept) begin
				if (access.mode == erfi_pkg::EV_PORT) begin
					if (arm_hit)
						armed_q <= 1'b1;
					if (dir != erfi_pkg::DIR_NONE) begin
						run_counter_q <= run_next;
						last_dir_q    <= dir;
						run_start_q   <= 1'b0;
					end
				end else if (done_set) begin
					done_q <= 1'b1;
				end
			end
			if (access.ready)
				out_valid_q <= access.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_out_q <= data_res;
			action_q   <= action_res;
		end
	end

	// a port C beat never carries a byte, a port beat never an action
	a_result_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && action_q != erfi_pkg::HA_NORMAL |-> data_out_q == '0)
		else $error("result beat carries both a byte and an action");

	// a new direction always opens a new run
	a_run_advance: assert property (@(posedge clk) disable iff (!arst_n)
		last_dir_q != $past(last_dir_q) |->
			run_counter_q == $past(run_counter_q) + erfi_pkg::RUN_W'(1))
		else $error("direction changed without a run advance");

	// the intervention completes only once armed and stays completed
	a_done_armed: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_q) |-> $past(armed_q))
		else $error("handoff completed without arming");

	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> done_q)
		else $error("handoff completion cleared");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result.ready |=> out_valid_q && $stable(data_out_q) &&
			$stable(action_q))
		else $error("stalled result register changed");

endmodule

`default_nettype wire

[hw/rtl/erfi_cfg.sv]
// ----------------------------------------------------------------------------
// erfi_cfg: configuration registers
// APB-style register file holding the slot words and handoff settings.
// ----------------------------------------------------------------------------
`default_nettype none

module erfi_cfg (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [erfi_pkg::CFG_ADDR_W-1:0]     paddr,
	input  wire logic [erfi_pkg::CFG_DATA_W-1:0]     pwdata,
	output logic      [erfi_pkg::CFG_DATA_W-1:0]     prdata,
	output erfi_pkg::cfg_t                           cfg
);

	erfi_pkg::cfg_t                       cfg_q;
	logic [erfi_pkg::REG_IDX_W-1:0]       idx;
	logic                                 wr_en;

	// registers sit on 8-byte boundaries
	assign idx   = paddr[erfi_pkg::CFG_ADDR_W-1 -: erfi_pkg::REG_IDX_W];
	assign wr_en = psel && penable && pwrite;
	assign cfg   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (idx) inside
				erfi_pkg::REG_SLOT0, erfi_pkg::REG_SLOT1,
				erfi_pkg::REG_SLOT2, erfi_pkg::REG_SLOT3: begin
					cfg_q.slot[idx[1:0]] <= pwdata[erfi_pkg::SLOT_W-1:0];
				end
				erfi_pkg::REG_TARGET: begin
					cfg_q.target <= pwdata[erfi_pkg::TARGET_W-1:0];
				end
				erfi_pkg::REG_HMODE: begin
					cfg_q.hmode <= pwdata[erfi_pkg::HMODE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx) inside
			erfi_pkg::REG_SLOT0, erfi_pkg::REG_SLOT1,
			erfi_pkg::REG_SLOT2, erfi_pkg::REG_SLOT3: begin
				prdata = erfi_pkg::CFG_DATA_W'(cfg_q.slot[idx[1:0]]);
			end
			erfi_pkg::REG_TARGET: prdata = erfi_pkg::CFG_DATA_W'(cfg_q.target);
			erfi_pkg::REG_HMODE:  prdata = erfi_pkg::CFG_DATA_W'(cfg_q.hmode);
			default:              prdata = '0;
		endcase
	end

endmodule

`default_nettype wire
